/* rtl/core/lmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_pkg
// Shared types and constants of the line median filter: the result entry
// held in the output queue, queue sizing and the register map.
// ----------------------------------------------------------------------------
package lmf_pkg;

  localparam int PIX_W       = 8;
  localparam int INDEX_W     = 7;
  localparam int WIN_DEPTH   = 5;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Word index of the window mode configuration register.
  localparam logic REG_WINDOW_MODE = 1'b0;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [INDEX_W-1:0] index;
    logic               line_end;
    logic               run_last;
  } entry_t;

endpackage

/* rtl/core/lmf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_cell
// One tap of the pixel window. Takes its neighbor's pixel on every shift.
// ----------------------------------------------------------------------------
module lmf_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift,
  input  logic [lmf_pkg::PIX_W-1:0] d,
  output logic [lmf_pkg::PIX_W-1:0] q
);
  import lmf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* rtl/core/lmf_median.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_median
// Median of the newest three or five window taps by rank selection: every
// tap counts the taps below and equal to it, and the tap whose rank range
// covers the middle position is chosen.
// ----------------------------------------------------------------------------
module lmf_median (
  input  logic                                    wide,
  input  logic [lmf_pkg::WIN_DEPTH-1:0][lmf_pkg::PIX_W-1:0] win,
  output logic [lmf_pkg::PIX_W-1:0]               median
);
  import lmf_pkg::*;

  always_comb begin
    logic [2:0] less;
    logic [2:0] equal;
    logic [2:0] mid;
    int         n;
    n      = wide ? 5 : 3;
    mid    = wide ? 3'd2 : 3'd1;
    median = win[0];
    // Walk down so the lowest qualifying tap wins.
    for (int k = WIN_DEPTH - 1; k >= 0; k--) begin
      less  = '0;
      equal = '0;
      for (int m = 0; m < WIN_DEPTH; m++) begin
        if (m < n) begin
          if (win[m] < win[k]) begin
            less = less + 3'd1;
          end else if (win[m] == win[k]) begin
            equal = equal + 3'd1;
          end
        end
      end
      if (k < n && less <= mid && mid < less + equal) begin
        median = win[k];
      end
    end
  end

endmodule

/* rtl/core/lmf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmf_queue
// Output queue of result entries. Takes up to three entries per cycle in
// order and hands out one per transfer from its head.
// ----------------------------------------------------------------------------
module lmf_queue (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic [1:0]                                  push_n,
  input  lmf_pkg::entry_t [lmf_pkg::MAX_RESULTS-1:0]  push_data,
  input  logic                                        pop,
  output lmf_pkg::entry_t                             head,
  output logic                                        not_empty,
  output logic [lmf_pkg::QCNT_W-1:0]                  count
);
  import lmf_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push_n) begin
        mem[wr_ptr + QPTR_W'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);

endmodule

/* rtl/core/line_median_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_median_filter
// Sliding-window median filter for a line sensor: a chain of five pixel
// cells, a rank-selection median unit and an output queue.
// ----------------------------------------------------------------------------
// The block takes one 8-bit pixel per transfer, LINE_PIXELS pixels to a
// line, and can accept a pixel in every clock cycle with pixel_ready high.
// Each pixel comes back replaced by the median of the three- or five-pixel
// window centred on it; the first and last one (three-pixel) or two
// (five-pixel) pixels of a line come back raw. The window size is taken
// from window_mode when the first pixel of a line is accepted and holds
// for that whole line. A result leaves half a window behind its input,
// and the last pixel of a line flushes the rest, so that pixel causes two
// or three result transfers; run_last marks the final result caused by
// each input pixel and line_end the last pixel of each line. When the
// pixel that completes a window is accepted, the cells and the median-stage
// registers take it, the median is formed combinationally from the cells,
// and the result is written into the eight-entry output queue, from whose
// head it can leave. The output side moves one result per cycle while
// result_ready is high; pixel_ready drops only while the queue, counting
// the pixel still in the median stage, has no room for three more results,
// which happens when the output side stalls. The window is not carried
// across lines: the position counter returns to zero after the last pixel
// and the taps of the old line are never read for the next one.
// ----------------------------------------------------------------------------
module line_median_filter #(
  parameter int LINE_PIXELS = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel input channel
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [lmf_pkg::PIX_W-1:0]     pixel_in,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [lmf_pkg::PIX_W-1:0]     pixel_out,
  output logic [lmf_pkg::INDEX_W-1:0]   pixel_index,
  output logic                          line_end,
  output logic                          run_last,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lmf_pkg::*;

  localparam int POS_W = $clog2(LINE_PIXELS);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_PIXELS - 1);

  // --------------------------------------------------------------------------
  // Configuration register. Only the word index is decoded.
  // --------------------------------------------------------------------------
  logic window_mode;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= 1'b0;
    end else if (cfg_write && paddr[2] == REG_WINDOW_MODE) begin
      window_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_MODE) ? {31'd0, window_mode} : 32'd0;

  // --------------------------------------------------------------------------
  // Input side: line position, the window size of the current line, and the
  // cell chain. Cell 0 holds the newest pixel once the transfer is taken.
  // --------------------------------------------------------------------------
  logic             pixel_take;
  logic [POS_W-1:0] line_pos;
  logic             active_mode;
  logic             item_mode;

  assign pixel_take = pixel_valid && pixel_ready;
  assign item_mode  = (line_pos == '0) ? window_mode : active_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos    <= '0;
      active_mode <= 1'b0;
    end else if (pixel_take) begin
      active_mode <= item_mode;
      if (line_pos == LAST_POS) begin
        line_pos <= '0;
      end else begin
        line_pos <= line_pos + 1'b1;
      end
    end
  end

  logic [WIN_DEPTH-1:0][PIX_W-1:0] win;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    lmf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (pixel_take),
      .d     ((i == 0) ? pixel_in : win[(i == 0) ? 0 : i - 1]),
      .q     (win[i])
    );
  end

  // --------------------------------------------------------------------------
  // Median stage. It works on the pixel taken in the previous cycle, while
  // the cells still hold the window that pixel completed.
  // --------------------------------------------------------------------------
  logic             st_valid;
  logic [POS_W-1:0] st_pos;
  logic             st_mode;
  logic             st_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= pixel_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      st_pos  <= line_pos;
      st_mode <= item_mode;
      st_done <= (line_pos == LAST_POS);
    end
  end

  logic [PIX_W-1:0] median;

  lmf_median u_median (
    .wide   (st_mode),
    .win    (win),
    .median (median)
  );

  logic [POS_W-1:0] half;
  logic [POS_W-1:0] centre;
  logic             has_centre;
  logic [1:0]       st_n;
  entry_t [MAX_RESULTS-1:0] res;

  assign half       = st_mode ? POS_W'(2) : POS_W'(1);
  assign centre     = st_pos - half;
  assign has_centre = (st_pos >= half);

  always_comb begin
    res = '0;
    // Centre pixel of the window: raw near the line start, median otherwise.
    res[0].pixel    = (centre < half) ? win[half[2:0]] : median;
    res[0].index    = INDEX_W'(centre);
    res[0].line_end = 1'b0;
    res[0].run_last = !st_done;
    // End of line: flush the pixels still held back.
    if (st_mode) begin
      res[1].pixel    = win[1];
      res[1].index    = INDEX_W'(st_pos - 1'b1);
      res[1].line_end = 1'b0;
      res[1].run_last = 1'b0;
      res[2].pixel    = win[0];
      res[2].index    = INDEX_W'(st_pos);
      res[2].line_end = 1'b1;
      res[2].run_last = 1'b1;
    end else begin
      res[1].pixel    = win[0];
      res[1].index    = INDEX_W'(st_pos);
      res[1].line_end = 1'b1;
      res[1].run_last = 1'b1;
    end
  end

  always_comb begin
    if (!st_valid) begin
      st_n = 2'd0;
    end else if (st_done) begin
      st_n = st_mode ? 2'd3 : 2'd2;
    end else begin
      st_n = has_centre ? 2'd1 : 2'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue. A pixel is taken only if the queue has room for the
  // results of the pixel in the median stage plus three more results.
  // --------------------------------------------------------------------------
  entry_t            head;
  logic              q_not_empty;
  logic [QCNT_W-1:0] q_count;
  logic              result_take;

  assign result_take = result_valid && result_ready;

  lmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (st_n),
    .push_data (res),
    .pop       (result_take),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign pixel_ready  = (q_count + QCNT_W'(st_n)) <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS);
  assign result_valid = q_not_empty;
  assign pixel_out    = head.pixel;
  assign pixel_index  = head.index;
  assign line_end     = head.line_end;
  assign run_last     = head.run_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue count exceeds its depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    line_pos <= LAST_POS)
    else $error("line position beyond the last pixel");

  a_flush_follows: assert property (@(posedge clk) disable iff (rst)
    (pixel_take && line_pos == LAST_POS) |=> (st_valid && st_done && st_n >= 2'd2))
    else $error("last pixel of a line did not start a flush");

  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && line_end) |-> run_last)
    else $error("line end result not marked as final of its run");

endmodule

/* tb/sv/line_median_filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_median_filter_checker
// Watches the pixel, result and register channels of the line median filter,
// predicts every filtered result and compares it with what the block sends.
// ----------------------------------------------------------------------------
module line_median_filter_checker #(
  parameter int LINE_PIXELS = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  input  logic                        pixel_ready,
  input  logic [lmf_pkg::PIX_W-1:0]   pixel_in,
  input  logic                        result_valid,
  input  logic                        result_ready,
  input  logic [lmf_pkg::PIX_W-1:0]   pixel_out,
  input  logic [lmf_pkg::INDEX_W-1:0] pixel_index,
  input  logic                        line_end,
  input  logic                        run_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          error_count,
  output int                          pending,
  output int                          results_checked
);

  import lmf_pkg::*;

  localparam logic [2:0] ADDR_WINDOW_MODE = 3'(4 * int'(REG_WINDOW_MODE));

  logic             mode_reg;
  logic             line_mode;
  int               line_pos;
  logic [PIX_W-1:0] taps [WIN_DEPTH];
  entry_t           expected_filtered [$];

  // Median of the n newest pixels, by sorting a copy of the window.
  function automatic logic [PIX_W-1:0] window_median(input int n);
    logic [PIX_W-1:0] s [WIN_DEPTH];
    logic [PIX_W-1:0] t;
    int               i;
    int               j;
    for (i = 0; i < WIN_DEPTH; i++) s[i] = taps[i];
    for (i = 1; i < n; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] > t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return s[n/2];
  endfunction

  task automatic filter_pixel(input logic [PIX_W-1:0] pix);
    int     half;
    int     centre;
    int     k;
    logic   done;
    entry_t e;
    if (line_pos == 0) line_mode = mode_reg;
    half = line_mode ? 2 : 1;
    done = (line_pos == LINE_PIXELS - 1);
    for (k = WIN_DEPTH - 1; k > 0; k--) taps[k] = taps[k-1];
    taps[0] = pix;
    if (line_pos >= half) begin
      centre     = line_pos - half;
      e.pixel    = (centre < half) ? taps[half] : window_median(2 * half + 1);
      e.index    = INDEX_W'(centre);
      e.line_end = 1'b0;
      e.run_last = !done;
      expected_filtered.push_back(e);
    end
    if (done) begin
      // The last pixel flushes the raw tail of the line.
      for (k = half; k > 0; k--) begin
        e.pixel    = taps[k-1];
        e.index    = INDEX_W'(line_pos - (k - 1));
        e.line_end = (k == 1);
        e.run_last = (k == 1);
        expected_filtered.push_back(e);
      end
      for (k = 0; k < WIN_DEPTH; k++) taps[k] = '0;
      line_pos = 0;
    end else begin
      line_pos++;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic check_filtered();
    entry_t e;
    if (expected_filtered.size() == 0) begin
      $error("result transfer with no result expected (pixel_index %0d)", pixel_index);
      error_count++;
    end else begin
      e = expected_filtered.pop_front();
      compare_field("pixel_out", 32'(e.pixel), 32'(pixel_out));
      compare_field("pixel_index", 32'(e.index), 32'(pixel_index));
      compare_field("line_end", 32'(e.line_end), 32'(line_end));
      compare_field("run_last", 32'(e.run_last), 32'(run_last));
    end
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_reg        = 1'b0;
      line_mode       = 1'b0;
      line_pos        = 0;
      for (int k = 0; k < WIN_DEPTH; k++) taps[k] = '0;
      expected_filtered.delete();
      error_count     = 0;
      results_checked = 0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_WINDOW_MODE) begin
        if (pwrite) mode_reg = pwdata[0];
        else compare_field("window_mode", {31'b0, mode_reg}, prdata);
      end
      if (pixel_valid && pixel_ready) filter_pixel(pixel_in);
      if (result_valid && result_ready) check_filtered();
    end
    pending = expected_filtered.size();
  end

endmodule

/* tb/sv/line_median_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_median_filter_tb
// Drives pixels and register writes into the line median filter and gives
// the verdict; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module line_median_filter_tb;

  import lmf_pkg::*;

  localparam int LINE_PIXELS   = 128;
  localparam int PHASE_PIXELS  = 70;
  localparam int HOLD_CYCLES   = 60;
  // Settling margin; covers pixels still in the window.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 100000;

  // Register map: a register index times four gives its byte address. The
  // spare index names no register, so writes to it must have no effect.
  localparam int         REG_SPARE        = 1;
  localparam logic [2:0] ADDR_WINDOW_MODE = 3'(4 * int'(REG_WINDOW_MODE));
  localparam logic [2:0] ADDR_SPARE       = 3'(4 * REG_SPARE);

  // Opening pixels of the run: both extremes, alternating bit patterns, runs
  // of equal values (median ties) and single spikes. First pixel is leftmost.
  localparam int DIRECTED_COUNT = 20;
  localparam logic [DIRECTED_COUNT*PIX_W-1:0] DIRECTED_PIXELS = {
    8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'h55, 8'hAA, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h07, 8'h07
  };

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               pixel_valid  = 1'b0;
  logic               pixel_ready;
  logic [PIX_W-1:0]   pixel_in     = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [PIX_W-1:0]   pixel_out;
  logic [INDEX_W-1:0] pixel_index;
  logic               line_end;
  logic               run_last;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [2:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                 error_count;
  int                 pending;
  int                 results_checked;
  int                 pixels_sent  = 0;
  int                 cycle_count  = 0;
  int                 stall_pct    = 0;
  logic               receiver_hold = 1'b0;
  logic [PIX_W-1:0]   last_pixel   = '0;
  event               hold_start;

  always #10 clk = ~clk;

  line_median_filter #(
    .LINE_PIXELS (LINE_PIXELS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .pixel_index  (pixel_index),
    .line_end     (line_end),
    .run_last     (run_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  line_median_filter_checker #(
    .LINE_PIXELS (LINE_PIXELS)
  ) checker_i (
    .clk             (clk),
    .rst             (rst),
    .pixel_valid     (pixel_valid),
    .pixel_ready     (pixel_ready),
    .pixel_in        (pixel_in),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .pixel_out       (pixel_out),
    .pixel_index     (pixel_index),
    .line_end        (line_end),
    .run_last        (run_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .error_count     (error_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // The run is cut off if it ever takes far longer than the slowest correct
  // run could, for example when the block stops sending results.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side. Ready is redrawn every falling edge from the stall rate of
  // the current phase. While a hold is running, ready stays low throughout.
  always @(negedge clk) begin
    result_ready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
  end

  // The long hold-off is counted here, independently of the pixel sender,
  // which keeps offering pixels so that the output queue fills and the block
  // has to drop pixel_ready.
  always begin
    @(hold_start);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    receiver_hold <= 1'b0;
  end

  // Random pixel content. Uniform values dominate; the rest are extremes,
  // repeats that make ties in the window, slow ramps and single spikes.
  function automatic logic [PIX_W-1:0] next_pixel();
    logic [PIX_W-1:0] p;
    case ($urandom_range(7))
      0, 1, 2: p = PIX_W'($urandom);
      3:       p = $urandom_range(1) ? 8'hFF : 8'h00;
      4:       p = last_pixel;
      5:       p = last_pixel + PIX_W'($urandom_range(3));
      6:       p = last_pixel - PIX_W'($urandom_range(3));
      default: p = last_pixel ^ 8'h80;
    endcase
    last_pixel = p;
    return p;
  endfunction

  // One pixel transfer. Called just after a falling edge; returns just after
  // the falling edge that follows the accepting rising edge. Valid may idle
  // low for a random number of cycles first, but once high it holds with the
  // same pixel until the block takes it.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_in    <= pix;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_pixels(input int count, input int idle_pct);
    int n;
    for (n = 0; n < count; n++) send_pixel(next_pixel(), idle_pct);
    pixel_valid <= 1'b0;
  endtask

  // APB write and read: a setup phase, an access phase, then an idle step with psel low
  // so that back-to-back accesses never assign psel twice in one step.
  task automatic reg_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Registers are touched only once every expected result has come out and
  // any pixel that causes no result yet has had time to settle in the window.
  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only bit 0 is the window mode; the upper bits are random and must be
  // dropped. The read-back is checked by the checker.
  task automatic set_window_mode(input logic mode);
    logic [31:0] junk;
    junk = $urandom;
    wait_idle();
    reg_access(1'b1, ADDR_WINDOW_MODE, {junk[31:1], mode});
    reg_access(1'b0, ADDR_WINDOW_MODE, '0);
  endtask

  // A write to an address that holds no register must leave the mode alone.
  task automatic poke_spare_register();
    wait_idle();
    reg_access(1'b1, ADDR_SPARE, 32'hFFFF_FFFF);
    reg_access(1'b0, ADDR_WINDOW_MODE, '0);
  endtask

  initial begin
    int i;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Line 0 starts in the three-pixel mode left by reset. The spare write
    // shows that an unknown register does not switch it to five pixels.
    poke_spare_register();
    set_window_mode(1'b0);

    // Directed pixels with no idling: extremes, bit patterns, ties and the
    // raw left edge of a three-pixel line.
    for (i = 0; i < DIRECTED_COUNT; i++)
      send_pixel(DIRECTED_PIXELS[PIX_W*(DIRECTED_COUNT-1-i) +: PIX_W], 0);
    pixel_valid <= 1'b0;

    // Switch to five pixels in the middle of line 0: the line must finish
    // with three-pixel windows and line 1 must pick up five.
    set_window_mode(1'b1);

    // No idling on either side, but the receiver holds off for a long
    // stretch right at the start, so the block backs up and stalls pixels.
    ->hold_start;
    send_random_pixels(PHASE_PIXELS, 0);

    // Sender idle about half the time; line 0 ends in this phase and line 1
    // opens with the raw two-pixel edge of the five-pixel mode.
    set_window_mode(1'b1);
    send_random_pixels(PHASE_PIXELS, 51);

    // Back to three pixels in the middle of line 1; the change waits for
    // line 2. The receiver stalls about half the time.
    set_window_mode(1'b0);
    stall_pct <= 51;
    send_random_pixels(PHASE_PIXELS, 0);

    // Both sides idle at a light rate; line 1 ends with the three-result
    // flush and line 2 starts in the three-pixel mode.
    poke_spare_register();
    stall_pct <= 18;
    send_random_pixels(PHASE_PIXELS, 18);

    // Let the last results drain, then allow for anything still in flight.
    wait_idle();

    $display("Sent %0d pixels over three lines in both window sizes, with mid-line mode",
             pixels_sent);
    $display("changes, a long output stall and four idling mixes; %0d results checked.",
             results_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
